@@ hw/rtl/wcf_pkg.sv @@
package wcf_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int IN_ELEMS_DEF  = 4;
  localparam int OUT_ELEMS_DEF = 1;
  localparam int ELEM_BITS_DEF = 16;

  localparam int LANE_W    = 16;
  localparam int NUM_LANES = 4;

  typedef struct packed {
    logic empty;
    logic full;
    logic near_full;
    logic underflow;
    logic overflow;
  } wcf_flags_t;

endpackage

@@ hw/rtl/wcf_ram.sv @@
module wcf_ram #(
  parameter int ROWS  = wcf_pkg::DEPTH_DEF,
  parameter int ROW_W = wcf_pkg::LANE_W,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data_r
);

  logic [ROW_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/width_converting_fifo_core.sv @@
// An accepted item passes the stage-a register, then the stage-b register, from which its result leaves.
// Throughput: one item per cycle while out_stall is low; every item gives exactly one result.
// The front entry is read from a single-port-write row memory with a registered read,
// with a bypass when the row being read is written in the same cycle.
// Reset (rst_n low, synchronous) clears valid bits, pointers, count and the staging word;
// the entry memory is not cleared.
module width_converting_fifo_core #(
  parameter int DEPTH     = wcf_pkg::DEPTH_DEF,
  parameter int IN_ELEMS  = wcf_pkg::IN_ELEMS_DEF,
  parameter int OUT_ELEMS = wcf_pkg::OUT_ELEMS_DEF,
  parameter int ELEM_BITS = wcf_pkg::ELEM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_read_enable,
  input  logic                                in_write_enable,
  input  logic signed [wcf_pkg::LANE_W-1:0]   in_lane0,
  input  logic signed [wcf_pkg::LANE_W-1:0]   in_lane1,
  input  logic signed [wcf_pkg::LANE_W-1:0]   in_lane2,
  input  logic signed [wcf_pkg::LANE_W-1:0]   in_lane3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic                                out_is_almost_full,
  output logic                                out_underflow_error,
  output logic                                out_overflow_error,
  output logic signed [wcf_pkg::LANE_W-1:0]   out_lane0,
  output logic signed [wcf_pkg::LANE_W-1:0]   out_lane1,
  output logic signed [wcf_pkg::LANE_W-1:0]   out_lane2,
  output logic signed [wcf_pkg::LANE_W-1:0]   out_lane3
);
  import wcf_pkg::*;

  localparam bit WIDE      = IN_ELEMS > OUT_ELEMS;
  localparam int RATIO     = WIDE ? (IN_ELEMS / OUT_ELEMS) : (OUT_ELEMS / IN_ELEMS);
  localparam int EPR       = WIDE ? RATIO : 1;
  localparam int ROWS      = (DEPTH + EPR - 1) / EPR;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SUB_W     = (EPR > 1) ? $clog2(EPR) : 1;
  localparam int ENT_W     = OUT_ELEMS * ELEM_BITS;
  localparam int ROW_ELEMS = EPR * OUT_ELEMS;
  localparam int ROW_W     = ROW_ELEMS * ELEM_BITS;
  localparam int CNT_W     = $clog2(DEPTH + 2 * RATIO + 1);

  localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  FULL_ADD   = CNT_W'(RATIO);
  localparam logic [CNT_W-1:0]  ALMOST_ADD = CNT_W'(2 * RATIO);
  localparam logic [CNT_W-1:0]  PUSH_CNT   = CNT_W'(EPR);
  localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(ROWS - 1);
  localparam logic [SUB_W-1:0]  LAST_SUB   = SUB_W'(EPR - 1);

  logic                 a_vld_r;
  logic                 a_re_r;
  logic                 a_we_r;
  logic [ELEM_BITS-1:0] a_lane_r [NUM_LANES];
  logic [ELEM_BITS-1:0] in_lane_w [NUM_LANES];

  logic                 b_vld_r;
  wcf_flags_t           b_flags_r;
  logic [SUB_W-1:0]     b_sub_r;
  logic                 b_byp_r;
  logic [ROW_W-1:0]     b_byp_data_r;
  logic [ROW_W-1:0]     rd_data_r;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt_pop;
  logic [ROW_AW-1:0]    rd_row_r, rd_row_nxt;
  logic [SUB_W-1:0]     rd_sub_r, rd_sub_nxt;
  logic [ROW_AW-1:0]    wr_row_r, wr_row_nxt;

  logic                 b_adv, a_adv;
  logic                 pop_ok, uf_err;
  logic                 push, of_err;
  logic [ROW_W-1:0]     row_wdata;
  wcf_flags_t           flags_nxt;

  logic [ROW_W-1:0]     b_row;
  logic [ENT_W-1:0]     b_ent;
  logic [LANE_W-1:0]    out_lane_w [NUM_LANES];

  assign in_lane_w[0] = in_lane0[ELEM_BITS-1:0];
  assign in_lane_w[1] = in_lane1[ELEM_BITS-1:0];
  assign in_lane_w[2] = in_lane2[ELEM_BITS-1:0];
  assign in_lane_w[3] = in_lane3[ELEM_BITS-1:0];

  assign b_adv    = !b_vld_r || !out_stall;
  assign a_adv    = a_vld_r && b_adv;
  assign in_stall = a_vld_r && !b_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_re_r   <= in_read_enable;
      a_we_r   <= in_write_enable;
      a_lane_r <= in_lane_w;
    end
  end

  // pop first, then push
  always_comb begin
    pop_ok     = a_re_r && (cnt_r != '0);
    uf_err     = a_re_r && (cnt_r == '0);
    cnt_pop    = pop_ok ? (cnt_r - CNT_W'(1)) : cnt_r;
    rd_row_nxt = rd_row_r;
    rd_sub_nxt = rd_sub_r;
    if (pop_ok) begin
      if (rd_sub_r == LAST_SUB) begin
        rd_sub_nxt = '0;
        rd_row_nxt = (rd_row_r == LAST_ROW) ? '0 : (rd_row_r + ROW_AW'(1));
      end else begin
        rd_sub_nxt = rd_sub_r + SUB_W'(1);
      end
    end
    cnt_nxt    = push ? (cnt_pop + PUSH_CNT) : cnt_pop;
    wr_row_nxt = wr_row_r;
    if (push) begin
      wr_row_nxt = (wr_row_r == LAST_ROW) ? '0 : (wr_row_r + ROW_AW'(1));
    end
    flags_nxt.empty       = (cnt_nxt == '0);
    flags_nxt.full        = WIDE ? ((cnt_nxt + FULL_ADD) > DEPTH_C) : (cnt_nxt >= DEPTH_C);
    flags_nxt.near_full   = (cnt_nxt + ALMOST_ADD) > DEPTH_C;
    flags_nxt.underflow   = uf_err;
    flags_nxt.overflow    = of_err;
  end

  generate
    if (WIDE) begin : g_wide
      logic fits;

      assign fits   = (cnt_pop + FULL_ADD) <= DEPTH_C;
      assign push   = a_we_r && fits;
      assign of_err = a_we_r && !fits;

      for (genvar e = 0; e < ROW_ELEMS; e++) begin : g_elem
        assign row_wdata[e*ELEM_BITS +: ELEM_BITS] = a_lane_r[e];
      end
    end else begin : g_narrow
      logic [ENT_W-1:0] stg_word_r, stg_word_nxt;
      logic [1:0]       stg_idx_r, stg_idx_nxt;
      logic             last;
      logic             room;

      for (genvar p = 0; p < OUT_ELEMS; p++) begin : g_pos
        localparam logic [1:0] SLOT = 2'(p / IN_ELEMS);
        localparam int         LN   = p % IN_ELEMS;
        assign stg_word_nxt[p*ELEM_BITS +: ELEM_BITS] =
          (a_we_r && stg_idx_r == SLOT) ? a_lane_r[LN] : stg_word_r[p*ELEM_BITS +: ELEM_BITS];
      end

      assign last        = stg_idx_r >= 2'(RATIO - 1);
      assign room        = cnt_pop < DEPTH_C;
      assign push        = a_we_r && last && room;
      assign of_err      = a_we_r && last && !room;
      assign row_wdata   = stg_word_nxt;
      assign stg_idx_nxt = !a_we_r ? stg_idx_r : (last ? 2'd0 : (stg_idx_r + 2'd1));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_word_r <= '0;
          stg_idx_r  <= '0;
        end else if (a_adv) begin
          stg_word_r <= stg_word_nxt;
          stg_idx_r  <= stg_idx_nxt;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_row_r <= '0;
      rd_sub_r <= '0;
      wr_row_r <= '0;
    end else if (a_adv) begin
      cnt_r    <= cnt_nxt;
      rd_row_r <= rd_row_nxt;
      rd_sub_r <= rd_sub_nxt;
      wr_row_r <= wr_row_nxt;
    end
  end

  wcf_ram #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (a_adv && push),
    .wr_addr   (wr_row_r),
    .wr_data   (row_wdata),
    .rd_en     (a_adv),
    .rd_addr   (rd_row_nxt),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_flags_r    <= flags_nxt;
      b_sub_r      <= rd_sub_nxt;
      b_byp_r      <= push && (wr_row_r == rd_row_nxt);
      b_byp_data_r <= row_wdata;
    end
  end

  assign b_row = b_byp_r ? b_byp_data_r : rd_data_r;
  assign b_ent = b_row[b_sub_r * ENT_W +: ENT_W];

  generate
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_out
      if (i < OUT_ELEMS) begin : g_used
        assign out_lane_w[i] = b_flags_r.empty ? '0 :
                               LANE_W'(signed'(b_ent[i*ELEM_BITS +: ELEM_BITS]));
      end else begin : g_unused
        assign out_lane_w[i] = '0;
      end
    end
  endgenerate

  assign out_valid           = b_vld_r;
  assign out_is_empty        = b_flags_r.empty;
  assign out_is_full         = b_flags_r.full;
  assign out_is_almost_full  = b_flags_r.near_full;
  assign out_underflow_error = b_flags_r.underflow;
  assign out_overflow_error  = b_flags_r.overflow;
  assign out_lane0           = out_lane_w[0];
  assign out_lane1           = out_lane_w[1];
  assign out_lane2           = out_lane_w[2];
  assign out_lane3           = out_lane_w[3];

endmodule

@@ hw/rtl/wcf_checker.sv @@
module wcf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_is_empty,
  input logic                              out_is_full,
  input logic                              out_is_almost_full,
  input logic                              out_underflow_error,
  input logic                              out_overflow_error,
  input logic signed [wcf_pkg::LANE_W-1:0] out_lane0,
  input logic signed [wcf_pkg::LANE_W-1:0] out_lane1,
  input logic signed [wcf_pkg::LANE_W-1:0] out_lane2,
  input logic signed [wcf_pkg::LANE_W-1:0] out_lane3
);
  import wcf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lane0) && $stable(out_lane1)
      && $stable(out_lane2) && $stable(out_lane3) && $stable(out_is_empty)
      && $stable(out_overflow_error) && $stable(out_underflow_error))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_lane0 == '0 && out_lane1 == '0
      && out_lane2 == '0 && out_lane3 == '0)
    else $error("empty result carries data");

  a_full_almost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_full |-> out_is_almost_full)
    else $error("full without almost full");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind width_converting_fifo_core wcf_checker u_wcf_checker (.*);

@@ tb/tb_width_converting_fifo_core.sv @@
`timescale 1ns / 1ps
module tb_width_converting_fifo_core;
  import wcf_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int IN_ELEMS  = IN_ELEMS_DEF;
  localparam int OUT_ELEMS = OUT_ELEMS_DEF;
  localparam int ELEM_BITS = ELEM_BITS_DEF;

  localparam bit WIDE  = IN_ELEMS > OUT_ELEMS;
  localparam int RATIO = WIDE ? IN_ELEMS / OUT_ELEMS : OUT_ELEMS / IN_ELEMS;
  localparam logic [LANE_W-1:0] ELEM_MASK = LANE_W'((1 << ELEM_BITS) - 1);

  localparam int RANDOM_ITEMS  = 1900;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic   rd;
    logic   wr;
    lanes_t lanes;
  } fifo_op_t;

  typedef struct packed {
    wcf_flags_t flags;
    lanes_t     lanes;
  } fifo_view_t;

  typedef struct packed {
    fifo_op_t   op;
    logic       known;
    fifo_view_t want;
  } plan_row_t;

  typedef enum int {FILL, DRAIN, STEADY} traffic_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_read_enable  = 1'b0;
  logic              in_write_enable = 1'b0;
  logic [LANE_W-1:0] in_lane0        = '0;
  logic [LANE_W-1:0] in_lane1        = '0;
  logic [LANE_W-1:0] in_lane2        = '0;
  logic [LANE_W-1:0] in_lane3        = '0;
  logic              out_stall       = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic              out_is_empty;
  logic              out_is_full;
  logic              out_is_almost_full;
  logic              out_underflow_error;
  logic              out_overflow_error;
  logic [LANE_W-1:0] out_lane0;
  logic [LANE_W-1:0] out_lane1;
  logic [LANE_W-1:0] out_lane2;
  logic [LANE_W-1:0] out_lane3;

  int unsigned cycle_count = 0;
  logic        calm;
  int          mismatches  = 0;

  fifo_view_t  pending_views[$];
  plan_row_t   plan[$];

  lanes_t mdl_mem [DEPTH];
  lanes_t mdl_stage;
  int     mdl_rd;
  int     mdl_wr;
  int     mdl_count;
  int     mdl_stage_idx;

  width_converting_fifo_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_read_enable      (in_read_enable),
    .in_write_enable     (in_write_enable),
    .in_lane0            (in_lane0),
    .in_lane1            (in_lane1),
    .in_lane2            (in_lane2),
    .in_lane3            (in_lane3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_is_almost_full  (out_is_almost_full),
    .out_underflow_error (out_underflow_error),
    .out_overflow_error  (out_overflow_error),
    .out_lane0           (out_lane0),
    .out_lane1           (out_lane1),
    .out_lane2           (out_lane2),
    .out_lane3           (out_lane3)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // no idling in this window
  assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** width_converting_fifo_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 15);
  end

  task automatic store_entry(input lanes_t e);
    mdl_mem[mdl_wr] = e;
    mdl_wr = (mdl_wr + 1) % DEPTH;
    mdl_count++;
  endtask

  task automatic predict_fifo_view(input fifo_op_t op, output fifo_view_t v);
    lanes_t            ln;
    lanes_t            e;
    logic [LANE_W-1:0] x;
    logic              uf;
    logic              of;
    int                k;
    uf = 1'b0;
    of = 1'b0;
    v  = '0;
    for (int i = 0; i < NUM_LANES; i++) ln[i] = op.lanes[i] & ELEM_MASK;
    // pop first, then push
    if (op.rd) begin
      if (mdl_count == 0) begin
        uf = 1'b1;
      end else begin
        mdl_rd = (mdl_rd + 1) % DEPTH;
        mdl_count--;
      end
    end
    if (op.wr) begin
      if (WIDE) begin
        if (mdl_count > DEPTH - RATIO) begin
          of = 1'b1;
        end else begin
          for (int i = 0; i < RATIO; i++) begin
            e = '0;
            for (int j = 0; j < OUT_ELEMS; j++) begin
              k = i * OUT_ELEMS + j;
              if (k < NUM_LANES) e[j] = ln[k];
            end
            store_entry(e);
          end
        end
      end else begin
        for (int i = 0; i < IN_ELEMS; i++) begin
          k = mdl_stage_idx * IN_ELEMS + i;
          if (k < NUM_LANES) mdl_stage[k] = ln[i];
        end
        if (mdl_stage_idx >= RATIO - 1) begin
          mdl_stage_idx = 0;
          if (mdl_count >= DEPTH) of = 1'b1;
          else store_entry(mdl_stage);
        end else begin
          mdl_stage_idx = (mdl_stage_idx + 1) % NUM_LANES;
        end
      end
    end
    v.flags.empty       = (mdl_count == 0);
    v.flags.full        = WIDE ? (mdl_count > DEPTH - RATIO) : (mdl_count >= DEPTH);
    v.flags.near_full   = (mdl_count > DEPTH - 2 * RATIO);
    v.flags.underflow   = uf;
    v.flags.overflow    = of;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (mdl_count > 0 && i < OUT_ELEMS) begin
        x = mdl_mem[mdl_rd][i] & ELEM_MASK;
        if (x[ELEM_BITS-1]) x = x | ~ELEM_MASK;
        v.lanes[i] = x;
      end
    end
  endtask

  function automatic void plan_row(input logic rd, input logic wr,
                                   input logic [LANE_W-1:0] l0, input logic [LANE_W-1:0] l1,
                                   input logic [LANE_W-1:0] l2, input logic [LANE_W-1:0] l3,
                                   input logic known, input wcf_flags_t f,
                                   input logic [LANE_W-1:0] e0, input logic [LANE_W-1:0] e1,
                                   input logic [LANE_W-1:0] e2, input logic [LANE_W-1:0] e3);
    plan_row_t r;
    r.op.rd         = rd;
    r.op.wr         = wr;
    r.op.lanes      = {l3, l2, l1, l0};
    r.known         = known;
    r.want.flags    = f;
    r.want.lanes    = {e3, e2, e1, e0};
    plan.push_back(r);
  endfunction

  task automatic send_item(input fifo_op_t op, input logic known, input fifo_view_t want);
    fifo_view_t pred;
    while (!calm && ($urandom_range(0, 99) < 15)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_read_enable  <= op.rd;
    in_write_enable <= op.wr;
    in_lane0        <= op.lanes[0];
    in_lane1        <= op.lanes[1];
    in_lane2        <= op.lanes[2];
    in_lane3        <= op.lanes[3];
    do @(posedge clk); while (in_stall);
    predict_fifo_view(op, pred);
    pending_views.push_back(known ? want : pred);
  endtask

  always @(posedge clk) begin : check_results
    fifo_view_t got;
    fifo_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.flags = {out_is_empty, out_is_full, out_is_almost_full,
                   out_underflow_error, out_overflow_error};
      got.lanes = {out_lane3, out_lane2, out_lane1, out_lane0};
      if (pending_views.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: flags %b lanes %h", got.flags, got.lanes);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch at cycle %0d: flags exp %b got %b, lanes exp %h got %h",
                     cycle_count, want.flags, got.flags, want.lanes, got.lanes);
          mismatches++;
        end
      end
    end
  end

  initial begin
    fifo_op_t  op;
    plan_row_t r;
    traffic_t  traffic;
    int        wr_pct;
    int        rd_pct;

    mdl_stage     = '0;
    mdl_rd        = 0;
    mdl_wr        = 0;
    mdl_count     = 0;
    mdl_stage_idx = 0;
    traffic       = STEADY;
    wr_pct        = 0;
    rd_pct        = 0;

    // flags: empty, full, near_full, underflow, overflow
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b1, 5'b10010, '0, '0, '0, '0);
    plan_row(1'b0, 1'b1, 16'h8000, 16'h7fff, 16'hffff, 16'h0000,
             1'b1, 5'b00000, 16'h8000, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b1, 5'b00000, 16'h7fff, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b1, 5'b00000, 16'hffff, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b1, 5'b10000, '0, '0, '0, '0);
    // pop on empty with a write in the same cycle
    plan_row(1'b1, 1'b1, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
             1'b1, 5'b00010, 16'h1111, '0, '0, '0);
    plan_row(1'b0, 1'b1, 16'haaaa, 16'h5555, 16'h0001, 16'hfffe,
             1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b0, 1'b1, 16'h7fff, 16'h8000, 16'h0000, 16'hffff,
             1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b0, 1'b1, 16'h0f0f, 16'hf0f0, 16'h00ff, 16'hff00,
             1'b0, '0, '0, '0, '0, '0);
    // write that does not fit
    plan_row(1'b0, 1'b1, 16'hdead, 16'hbeef, 16'hcafe, 16'hf00d,
             1'b1, 5'b01101, 16'h1111, '0, '0, '0);
    plan_row(1'b1, 1'b1, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0,
             1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
             1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b0, 1'b0, 16'h5a5a, 16'ha5a5, 16'h5a5a, 16'ha5a5,
             1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
    plan_row(1'b1, 1'b0, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      send_item(r.op, r.known, r.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) traffic = traffic_t'($urandom_range(0, 2));
      case (traffic)
        FILL: begin
          wr_pct = 50;
          rd_pct = 30;
        end
        DRAIN: begin
          wr_pct = 5;
          rd_pct = 90;
        end
        default: begin
          wr_pct = 22;
          rd_pct = 85;
        end
      endcase
      op.rd = ($urandom_range(0, 99) < rd_pct);
      op.wr = ($urandom_range(0, 99) < wr_pct);
      for (int i = 0; i < NUM_LANES; i++) begin
        case ($urandom_range(0, 7))
          0:       op.lanes[i] = 16'h8000;
          1:       op.lanes[i] = 16'h7fff;
          2:       op.lanes[i] = 16'hffff;
          3:       op.lanes[i] = 16'h0000;
          default: op.lanes[i] = LANE_W'($urandom);
        endcase
      end
      send_item(op, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("** width_converting_fifo_core: PASSED **");
    end else begin
      $display("** width_converting_fifo_core: FAILED **");
    end
    $finish;
  end

endmodule
